// ----- design/sha256_byte_stream_hasher_assert.svh -----
// ----------------------------------------------------------------------------
// sha256 hasher assertion macros
// shared property wrappers for the checker, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH

// same-cycle implication
`define SHA256_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sha256 assertion failed");

// next-cycle implication
`define SHA256_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sha256 assertion failed");

`endif

// ----- design/sha256_pkg.sv -----
// ----------------------------------------------------------------------------
// sha256 package
// shared types, round constants and initial hash values
// ----------------------------------------------------------------------------
package sha256_pkg;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD_MARK,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_ROUND,
      ST_ADD,
      ST_EMIT
   } state_type;

   // source of the byte shifted into the block buffer
   typedef enum logic [1:0] {
      SEL_MSG,
      SEL_MARK,
      SEL_ZERO,
      SEL_LEN
   } byte_sel_type;

   // controller to datapath commands
   typedef struct packed {
      logic         shift;
      byte_sel_type byte_sel;
      logic [2:0]   len_idx;
      logic         count_byte;
      logic         round;
      logic [5:0]   round_idx;
      logic         add;
      logic         restart;
      logic [2:0]   word_idx;
   } dp_cmd_type;

   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam logic [5:0] LAST_FILL  = 6'd63;
   localparam logic [5:0] LEN_FILL   = 6'd56;
   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [2:0] LAST_WORD  = 3'd7;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage

// ----- design/sha256_if.sv -----
// ----------------------------------------------------------------------------
// sha256 channel interfaces
// valid/ready channels for message bytes and digest words
// ----------------------------------------------------------------------------

// message byte channel
interface sha256_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] msg_byte;
   logic       byte_valid;
   logic       end_of_message;

   modport source (output valid, msg_byte, byte_valid, end_of_message, input ready);
   modport sink   (input valid, msg_byte, byte_valid, end_of_message, output ready);
endinterface

// digest word channel
interface sha256_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  word_index;
   logic [31:0] digest_word;
   logic        last_word;

   modport source (output valid, word_index, digest_word, last_word, input ready);
   modport sink   (input valid, word_index, digest_word, last_word, output ready);
endinterface

// ----- design/sha256_ctrl.sv -----
// ----------------------------------------------------------------------------
// sha256 controller
// sequences byte intake, padding, compression rounds and digest output
// ----------------------------------------------------------------------------
module sha256_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   byte_valid,
   input  logic                   end_of_message,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             word_index,
   output logic                   last_word,
   output sha256_pkg::dp_cmd_type cmd
);

   sha256_pkg::state_type state_ff, state_in;
   sha256_pkg::state_type ret_ff, ret_in;
   logic [5:0] fill_ff, fill_in;
   logic [5:0] round_ff, round_in;
   logic [2:0] word_ff, word_in;
   logic       block_full;

   assign block_full = (fill_ff == sha256_pkg::LAST_FILL);

   // next state
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      case (state_ff)
         sha256_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (byte_valid && block_full) begin
                  state_in = sha256_pkg::ST_ROUND;
                  ret_in   = end_of_message ? sha256_pkg::ST_PAD_MARK : sha256_pkg::ST_IDLE;
               end else if (end_of_message) begin
                  state_in = sha256_pkg::ST_PAD_MARK;
               end
            end
         end
         sha256_pkg::ST_PAD_MARK: begin
            if (block_full) begin
               state_in = sha256_pkg::ST_ROUND;
               ret_in   = sha256_pkg::ST_PAD_ZERO;
            end else begin
               state_in = sha256_pkg::ST_PAD_ZERO;
            end
         end
         sha256_pkg::ST_PAD_ZERO: begin
            if (fill_ff == sha256_pkg::LEN_FILL) begin
               state_in = sha256_pkg::ST_PAD_LEN;
            end else if (block_full) begin
               state_in = sha256_pkg::ST_ROUND;
               ret_in   = sha256_pkg::ST_PAD_ZERO;
            end
         end
         sha256_pkg::ST_PAD_LEN: begin
            if (block_full) begin
               state_in = sha256_pkg::ST_ROUND;
               ret_in   = sha256_pkg::ST_EMIT;
            end
         end
         sha256_pkg::ST_ROUND: begin
            if (round_ff == sha256_pkg::LAST_ROUND) begin
               state_in = sha256_pkg::ST_ADD;
            end
         end
         sha256_pkg::ST_ADD: begin
            state_in = ret_ff;
         end
         sha256_pkg::ST_EMIT: begin
            if (rsp_ready && (word_ff == sha256_pkg::LAST_WORD)) begin
               state_in = sha256_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sha256_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs and datapath commands
   always_comb begin
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      cmd            = '0;
      cmd.byte_sel   = sha256_pkg::SEL_ZERO;
      cmd.len_idx    = fill_ff[2:0];
      cmd.round_idx  = round_ff;
      cmd.word_idx   = word_ff;
      case (state_ff)
         sha256_pkg::ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.shift      = req_valid && byte_valid;
            cmd.count_byte = req_valid && byte_valid;
            cmd.byte_sel   = sha256_pkg::SEL_MSG;
         end
         sha256_pkg::ST_PAD_MARK: begin
            cmd.shift    = 1'b1;
            cmd.byte_sel = sha256_pkg::SEL_MARK;
         end
         sha256_pkg::ST_PAD_ZERO: begin
            cmd.shift = (fill_ff != sha256_pkg::LEN_FILL);
         end
         sha256_pkg::ST_PAD_LEN: begin
            cmd.shift    = 1'b1;
            cmd.byte_sel = sha256_pkg::SEL_LEN;
         end
         sha256_pkg::ST_ROUND: begin
            cmd.round = 1'b1;
         end
         sha256_pkg::ST_ADD: begin
            cmd.add = 1'b1;
         end
         sha256_pkg::ST_EMIT: begin
            rsp_valid   = 1'b1;
            cmd.restart = rsp_ready && (word_ff == sha256_pkg::LAST_WORD);
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // counters
   always_comb begin
      fill_in  = cmd.shift ? fill_ff + 6'd1 : fill_ff;
      round_in = cmd.round ? round_ff + 6'd1 : 6'd0;
      word_in  = (rsp_valid && rsp_ready) ? word_ff + 3'd1 : word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha256_pkg::ST_IDLE;
         ret_ff   <= sha256_pkg::ST_IDLE;
         fill_ff  <= 6'd0;
         round_ff <= 6'd0;
         word_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         fill_ff  <= fill_in;
         round_ff <= round_in;
         word_ff  <= word_in;
      end
   end

   assign word_index = word_ff;
   assign last_word  = (word_ff == sha256_pkg::LAST_WORD);

endmodule

// ----- design/sha256_dp.sv -----
// ----------------------------------------------------------------------------
// sha256 datapath
// block buffer doubling as schedule shift line, round unit, chaining words
// ----------------------------------------------------------------------------
module sha256_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  sha256_pkg::dp_cmd_type cmd,
   input  logic [7:0]             msg_byte,
   output logic [31:0]            digest_word
);

   logic [31:0] block_ff [16];
   logic [31:0] block_in [16];
   logic [31:0] hash_ff  [8];
   logic [31:0] hash_in  [8];
   logic [31:0] work_ff  [8];
   logic [31:0] work_in  [8];
   logic [63:0] bitlen_ff, bitlen_in;
   logic [7:0]  shift_byte;
   logic [31:0] sched_word;
   logic [31:0] t1, t2;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_s0(input logic [31:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_s1(input logic [31:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_s0(input logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_s1(input logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   // byte source for the block buffer
   always_comb begin
      case (cmd.byte_sel)
         sha256_pkg::SEL_MSG:  shift_byte = msg_byte;
         sha256_pkg::SEL_MARK: shift_byte = sha256_pkg::PAD_BYTE;
         sha256_pkg::SEL_LEN:  shift_byte = bitlen_ff[{~cmd.len_idx, 3'b000} +: 8];
         default:              shift_byte = 8'h00;
      endcase
   end

   // next schedule word from the fixed taps of the shift line
   assign sched_word = small_s1(block_ff[14]) + block_ff[9] + small_s0(block_ff[1]) + block_ff[0];

   // block buffer: byte shift on intake, word shift during rounds
   always_comb begin
      block_in = block_ff;
      if (cmd.shift) begin
         for (int i = 0; i < 15; i++) begin
            block_in[i] = {block_ff[i][23:0], block_ff[i+1][31:24]};
         end
         block_in[15] = {block_ff[15][23:0], shift_byte};
      end else if (cmd.round) begin
         for (int i = 0; i < 15; i++) begin
            block_in[i] = block_ff[i+1];
         end
         block_in[15] = sched_word;
      end
   end

   // one compression round
   assign t1 = work_ff[7] + big_s1(work_ff[4])
             + ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]))
             + sha256_pkg::ROUND_K[cmd.round_idx] + block_ff[0];
   assign t2 = big_s0(work_ff[0])
             + ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
                ^ (work_ff[1] & work_ff[2]));

   always_comb begin
      if (cmd.round) begin
         work_in[0] = t1 + t2;
         work_in[1] = work_ff[0];
         work_in[2] = work_ff[1];
         work_in[3] = work_ff[2];
         work_in[4] = work_ff[3] + t1;
         work_in[5] = work_ff[4];
         work_in[6] = work_ff[5];
         work_in[7] = work_ff[6];
      end else begin
         work_in = hash_ff;
      end
   end

   // chaining words and message length
   always_comb begin
      hash_in   = hash_ff;
      bitlen_in = bitlen_ff;
      if (cmd.restart) begin
         hash_in   = sha256_pkg::INIT_HASH;
         bitlen_in = 64'd0;
      end else begin
         if (cmd.add) begin
            for (int i = 0; i < 8; i++) begin
               hash_in[i] = hash_ff[i] + work_ff[i];
            end
         end
         if (cmd.count_byte) begin
            bitlen_in = bitlen_ff + 64'd8;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff   <= sha256_pkg::INIT_HASH;
         bitlen_ff <= 64'd0;
      end else begin
         hash_ff   <= hash_in;
         bitlen_ff <= bitlen_in;
      end
   end

   always_ff @(posedge clock) begin
      block_ff <= block_in;
      work_ff  <= work_in;
   end

   assign digest_word = hash_ff[cmd.word_idx];

endmodule

// ----- design/sha256_byte_stream_hasher.sv -----
// A byte transaction is taken while the controller is idle; a full 64-byte block is then compressed
// (64 rounds on one shared round unit, then a fold into the chaining words).
// End of message: padding (0x80 mark, zeros, 64-bit length) plus one or two compressions,
// then 8 digest transactions, one per cycle while rsp is ready.
// No new bytes are taken during compression, padding or digest output.
// Reset (synchronous): initial hash values, zero length and fill; block buffer not cleared.
// ----------------------------------------------------------------------------
// sha256 byte stream hasher
// top level joining the controller and the datapath to the two channels
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
   input  logic              clock,
   input  logic              reset,
   sha256_req_if.sink        req_chan,
   sha256_rsp_if.source      rsp_chan
);

   sha256_pkg::dp_cmd_type cmd;
   logic                   req_ready;
   logic                   rsp_valid;
   logic [2:0]             word_index;
   logic                   last_word;
   logic [31:0]            digest_word;

   // sequencer
   sha256_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .byte_valid     (req_chan.byte_valid),
      .end_of_message (req_chan.end_of_message),
      .req_ready      (req_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_chan.ready),
      .word_index     (word_index),
      .last_word      (last_word),
      .cmd            (cmd)
   );

   // hashing datapath
   sha256_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .msg_byte    (req_chan.msg_byte),
      .digest_word (digest_word)
   );

   assign req_chan.ready       = req_ready;
   assign rsp_chan.valid       = rsp_valid;
   assign rsp_chan.word_index  = word_index;
   assign rsp_chan.digest_word = digest_word;
   assign rsp_chan.last_word   = last_word;

endmodule

// ----- design/sha256_checker.sv -----
// ----------------------------------------------------------------------------
// sha256 port checker
// watches the channel ports of the hasher over time
// ----------------------------------------------------------------------------
`include "sha256_byte_stream_hasher_assert.svh"

module sha256_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  word_index,
   input logic [31:0] digest_word,
   input logic        last_word
);

   // no new transaction is taken while digest words go out
   `SHA256_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid, !req_ready)

   // final flag marks the eighth word only
   `SHA256_ASSERT_IMPL(a_last_flag, clock, reset, rsp_valid, last_word == (word_index == 3'd7))

   // a stalled digest word holds
   `SHA256_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(digest_word) && $stable(word_index))

   // words go out back to back in order
   `SHA256_ASSERT_NEXT(a_word_order, clock, reset, rsp_valid && rsp_ready && !last_word,
      rsp_valid && (word_index == 3'($past(word_index) + 3'd1)))

   // ready for the next message right after the last word
   `SHA256_ASSERT_NEXT(a_restart, clock, reset, rsp_valid && rsp_ready && last_word,
      req_ready && !rsp_valid)

endmodule

bind sha256_byte_stream_hasher sha256_checker u_sha256_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .word_index  (rsp_chan.word_index),
   .digest_word (rsp_chan.digest_word),
   .last_word   (rsp_chan.last_word)
);
